@@ design/rvb_pkg.sv @@
// Shared types and constants for the region visited bitmap.
package rvb_pkg;

  localparam int unsigned REGION_EDGE_DEF = 64;
  localparam int unsigned WORD_COUNT_DEF  = 64;
  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned BIT_W           = 6;
  localparam int unsigned COUNT_W         = 13;
  localparam int unsigned REV_W           = 64;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    STATUS_OK  = 2'd0,
    STATUS_OOB = 2'd1,
    STATUS_OVF = 2'd2
  } status_t;

  typedef enum logic {
    REQ_DISCOVER = 1'b0,
    REQ_QUERY    = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

@@ design/region_visited_bitmap.sv @@
// Region visited bitmap: test-and-set of cells held in a word memory.
// An accepted item moves the FSM to ST_EXEC and done is registered from it;
// no new item is taken until it is back in ST_IDLE. The memory read is
// registered on accept, the modify and write-back happen in ST_EXEC, so the
// following read sees the write. Reset: rst clears counters, then a sweep
// zeroes all words in ST_CLEAR, busy high; the receiver cannot stall results.
module region_visited_bitmap #(
  parameter int unsigned REGION_EDGE = rvb_pkg::REGION_EDGE_DEF,
  parameter int unsigned WORD_COUNT  = rvb_pkg::WORD_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         req_type,
  input  logic [15:0]                  local_x,
  input  logic [15:0]                  local_z,
  output logic                         done,
  output rvb_pkg::status_t             status,
  output logic                         newly_set,
  output logic                         was_set,
  output logic [rvb_pkg::REV_W-1:0]    revision_now,
  output logic [rvb_pkg::COUNT_W-1:0]  cells_found
);
  import rvb_pkg::*;

  localparam int unsigned EW    = $clog2(REGION_EDGE);
  localparam int unsigned POS_W = $clog2(REGION_EDGE * REGION_EDGE);
  localparam int unsigned AW    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned IDX_W = POS_W + AW;

  logic [WORD_BITS-1:0] mem [WORD_COUNT];
  logic [WORD_BITS-1:0] rd_data;

  state_t state, state_next;
  logic [AW-1:0]  clr_addr;
  logic           clr_last;

  logic           accept;
  logic           coord_ok;
  logic           in_range;
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] word_sel;

  logic             s1_type;
  logic             s1_oob;
  logic [BIT_W-1:0] s1_bit;
  logic [AW-1:0]    s1_addr;

  logic [REV_W-1:0]   revision;
  logic [COUNT_W-1:0] cells;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] set_word;

  logic       prior;
  logic       do_set;
  status_t    res_status;
  logic       res_new;
  logic       res_was;

  assign accept   = start && !busy;
  assign coord_ok = (local_x < 16'(REGION_EDGE)) && (local_z < 16'(REGION_EDGE));
  assign pos      = IDX_W'(local_z[EW-1:0]) * IDX_W'(REGION_EDGE) + IDX_W'(local_x[EW-1:0]);
  assign word_sel = pos >> BIT_W;
  assign in_range = coord_ok && (word_sel < IDX_W'(WORD_COUNT));
  assign clr_last = (clr_addr == AW'(WORD_COUNT - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    case (state)
      ST_CLEAR: busy = 1'b1;
      ST_IDLE:  busy = 1'b0;
      ST_EXEC:  busy = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_comb begin
    set_word         = rd_data;
    set_word[s1_bit] = 1'b1;
    prior            = rd_data[s1_bit] && !s1_oob;
    do_set           = 1'b0;
    res_new          = 1'b0;
    res_was          = 1'b0;
    res_status       = STATUS_OK;
    if (s1_oob) begin
      res_status = STATUS_OOB;
    end else if (s1_type == REQ_QUERY || prior) begin
      res_was = prior;
    end else if (revision == '1) begin
      res_status = STATUS_OVF;
    end else begin
      do_set  = 1'b1;
      res_new = 1'b1;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr;
    mem_wdata = set_word;
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_EXEC && do_set) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (accept && in_range) begin
      rd_data <= mem[word_sel[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_type <= req_type;
      s1_oob  <= !in_range;
      s1_bit  <= pos[BIT_W-1:0];
      s1_addr <= word_sel[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      revision <= '0;
      cells    <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_EXEC);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_EXEC && do_set) begin
        revision <= revision + REV_W'(1);
        if (cells != COUNT_MAX) begin
          cells <= cells + COUNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC) begin
      status    <= res_status;
      newly_set <= res_new;
      was_set   <= res_was;
    end
  end

  assign revision_now = revision;
  assign cells_found  = cells;

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_EXEC))
    else $error("done without a preceding execute cycle");

  a_new_is_clean: assert property (@(posedge clk) disable iff (rst)
    (done && newly_set) |-> (status == STATUS_OK && !was_set))
    else $error("newly_set with bad status or prior bit");

  a_rev_bump: assert property (@(posedge clk) disable iff (rst)
    (done && newly_set) |-> (revision_now == $past(revision_now) + REV_W'(1)))
    else $error("revision not bumped on a new mark");

  a_oob_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == STATUS_OOB) |-> (!was_set && !newly_set))
    else $error("out-of-bounds item reports a bit");

  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> busy)
    else $error("item accepted during clearing sweep");

endmodule
